/* src/assert_macros.svh */
// Assertion macros shared by the duplicate tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("duplicate tracker check failed");

// Check that cons holds in the cycle after ante.
`define FDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("duplicate tracker check failed");

`endif

/* src/fdt_pkg.sv */
// Types and constants of the flood duplicate tracker.
package fdt_pkg;

   localparam int PAIR_DEPTH    = 100;
   localparam int GATEWAY_DEPTH = 16;

   localparam int PAIR_IDX_W = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int PAIR_CNT_W = $clog2(PAIR_DEPTH + 1);
   localparam int GW_IDX_W   = (GATEWAY_DEPTH > 1) ? $clog2(GATEWAY_DEPTH) : 1;

   localparam logic [15:0] HITS_MAX  = 16'hFFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] origin_addr;
      logic [31:0] flood_seq;
      logic [31:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic        is_duplicate;
      logic [15:0] pair_count;
      logic [31:0] gateway_seen;
      logic [31:0] gateway_first;
      logic        gateway_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] seq;
      logic [15:0] hits;
   } pair_entry_type;

   localparam int PAIR_ENTRY_W = $bits(pair_entry_type);

   typedef struct packed {
      logic accept;
      logic scan;
      logic hit_wr;
      logic ins_wr;
   } cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_done;
      logic out_free;
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_INSERT
   } state_type;

endpackage

/* src/fdt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fdt_datapath.sv */
// Datapath of the flood duplicate tracker: pair store scan, gateway table, result register.
`include "assert_macros.svh"

module fdt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  fdt_pkg::cmd_type    cmd,
   output fdt_pkg::status_type status,
   input  fdt_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fdt_pkg::rsp_type    rsp_data
);
   import fdt_pkg::*;

   // request and scan registers
   req_type               req_ff;
   logic [PAIR_CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                  pend_ff, pend_in;
   logic [PAIR_IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [PAIR_IDX_W-1:0] hit_idx_ff;
   logic [15:0]           hit_cnt_ff;
   logic [PAIR_CNT_W-1:0] fill_ff, fill_in;
   logic [PAIR_IDX_W-1:0] oldest_ff, oldest_in;

   // gateway table
   logic                  gw_valid_ff [GATEWAY_DEPTH];
   logic [31:0]           gw_addr_ff  [GATEWAY_DEPTH];
   logic [31:0]           gw_count_ff [GATEWAY_DEPTH];
   logic [31:0]           gw_first_ff [GATEWAY_DEPTH];
   logic                  gw_hit_ff, gw_hit_in;
   logic                  gw_free_ff, gw_free_in;
   logic [GW_IDX_W-1:0]   gw_idx_ff, gw_idx_in;

   // result register
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // RAM port signals
   logic                  issue;
   logic                  ram_wr_en;
   logic [PAIR_IDX_W-1:0] ram_wr_addr;
   pair_entry_type        ram_wr_data;
   pair_entry_type        ram_q;
   logic                  match;
   logic                  store_full;
   logic [15:0]           hits_next;
   logic [31:0]           count_next;

   fdt_ram #(
      .WIDTH (PAIR_ENTRY_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[PAIR_IDX_W-1:0]),
      .rd_data (ram_q)
   );

   // scan: one read issued per cycle, compared in the cycle after it is issued
   assign issue = cmd.scan && (rd_idx_ff < fill_ff);
   assign match = pend_ff && (ram_q.addr == req_ff.origin_addr)
                  && (ram_q.seq == req_ff.flood_seq);

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      if (cmd.accept) begin
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in  = rd_idx_ff + PAIR_CNT_W'(1);
         pend_in    = 1'b1;
         cmp_idx_in = rd_idx_ff[PAIR_IDX_W-1:0];
      end
   end

   assign status.scan_hit  = cmd.scan && match;
   assign status.scan_done = !(rd_idx_ff < fill_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // gateway lookup on the incoming request: lowest matching slot, else lowest free slot
   always_comb begin
      gw_hit_in  = 1'b0;
      gw_free_in = 1'b0;
      gw_idx_in  = '0;
      for (int i = GATEWAY_DEPTH - 1; i >= 0; i--) begin
         if (!gw_valid_ff[i]) begin
            gw_free_in = 1'b1;
         end
      end
      for (int i = GATEWAY_DEPTH - 1; i >= 0; i--) begin
         if (!gw_valid_ff[i]) begin
            gw_idx_in = GW_IDX_W'(i);
         end
      end
      for (int i = GATEWAY_DEPTH - 1; i >= 0; i--) begin
         if (gw_valid_ff[i] && (gw_addr_ff[i] == req_data.origin_addr)) begin
            gw_hit_in = 1'b1;
         end
      end
      if (gw_hit_in) begin
         for (int i = GATEWAY_DEPTH - 1; i >= 0; i--) begin
            if (gw_valid_ff[i] && (gw_addr_ff[i] == req_data.origin_addr)) begin
               gw_idx_in = GW_IDX_W'(i);
            end
         end
      end
   end

   // pair store write and ring bookkeeping
   assign store_full = (fill_ff == PAIR_CNT_W'(PAIR_DEPTH));
   assign hits_next  = (hit_cnt_ff == HITS_MAX) ? hit_cnt_ff : hit_cnt_ff + 16'd1;
   assign count_next = (gw_count_ff[gw_idx_ff] == COUNT_MAX) ? COUNT_MAX
                       : gw_count_ff[gw_idx_ff] + 32'd1;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = hit_idx_ff;
      ram_wr_data = '{addr: req_ff.origin_addr, seq: req_ff.flood_seq, hits: hits_next};
      fill_in     = fill_ff;
      oldest_in   = oldest_ff;
      if (cmd.hit_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.ins_wr) begin
         ram_wr_en        = 1'b1;
         ram_wr_data.hits = 16'd1;
         if (store_full) begin
            ram_wr_addr = oldest_ff;
            oldest_in   = (oldest_ff == PAIR_IDX_W'(PAIR_DEPTH - 1)) ? '0
                          : oldest_ff + PAIR_IDX_W'(1);
         end else begin
            ram_wr_addr = fill_ff[PAIR_IDX_W-1:0];
            fill_in     = fill_ff + PAIR_CNT_W'(1);
         end
      end
   end

   // result assembly
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.hit_wr) begin
         rsp_valid_in         = 1'b1;
         rsp_in.is_duplicate  = 1'b1;
         rsp_in.pair_count    = hits_next;
         rsp_in.gateway_seen  = '0;
         rsp_in.gateway_first = gw_hit_ff ? gw_first_ff[gw_idx_ff] : '0;
         rsp_in.gateway_full  = 1'b0;
      end else if (cmd.ins_wr) begin
         rsp_valid_in        = 1'b1;
         rsp_in.is_duplicate = 1'b0;
         rsp_in.pair_count   = 16'd1;
         if (gw_hit_ff) begin
            rsp_in.gateway_seen  = count_next;
            rsp_in.gateway_first = gw_first_ff[gw_idx_ff];
            rsp_in.gateway_full  = 1'b0;
         end else if (gw_free_ff) begin
            rsp_in.gateway_seen  = 32'd1;
            rsp_in.gateway_first = req_ff.now_ticks;
            rsp_in.gateway_full  = 1'b0;
         end else begin
            rsp_in.gateway_seen  = '0;
            rsp_in.gateway_first = '0;
            rsp_in.gateway_full  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         oldest_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GATEWAY_DEPTH; i++) begin
            gw_valid_ff[i] <= 1'b0;
         end
      end else begin
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.ins_wr && !gw_hit_ff && gw_free_ff) begin
            gw_valid_ff[gw_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
      if (cmd.accept) begin
         req_ff     <= req_data;
         gw_hit_ff  <= gw_hit_in;
         gw_free_ff <= gw_free_in;
         gw_idx_ff  <= gw_idx_in;
      end
      if (status.scan_hit) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_cnt_ff <= ram_q.hits;
      end
      if (cmd.ins_wr) begin
         if (gw_hit_ff) begin
            gw_count_ff[gw_idx_ff] <= count_next;
         end else if (gw_free_ff) begin
            gw_addr_ff[gw_idx_ff]  <= req_ff.origin_addr;
            gw_count_ff[gw_idx_ff] <= 32'd1;
            gw_first_ff[gw_idx_ff] <= req_ff.now_ticks;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FDT_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= PAIR_CNT_W'(PAIR_DEPTH))
   `FDT_ASSERT_NEXT(a_load_sets_valid, cmd.hit_wr || cmd.ins_wr, rsp_valid_ff)
   `FDT_ASSERT_NOW(a_dup_not_full, rsp_valid_ff, !(rsp_ff.is_duplicate && rsp_ff.gateway_full))

endmodule

/* src/fdt_ctrl.sv */
// Controller state machine of the flood duplicate tracker.
`include "assert_macros.svh"

module fdt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fdt_pkg::status_type status,
   output fdt_pkg::cmd_type    cmd
);
   import fdt_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_hit) begin
               state_in = ST_HIT;
            end else if (status.scan_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_HIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_INSERT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_HIT: begin
            cmd.hit_wr = status.out_free;
         end
         ST_INSERT: begin
            cmd.ins_wr = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FDT_ASSERT_NEXT(a_hold_until_free, (state_ff == ST_HIT) && !status.out_free,
                    state_ff == ST_HIT)

endmodule

/* src/flood_duplicate_tracker.sv */
// Flood duplicate tracker. Each request carries a flood's origin address, sequence number
// and the current time. The block remembers the PAIR_DEPTH most recent (address, sequence)
// pairs in an on-chip RAM with a saturating hit count each: a pair already held is reported
// as a duplicate with its raised count, and a new pair is stored, taking the oldest pair's
// place once the store is full. New pairs also update a table of GATEWAY_DEPTH origins that
// keeps a saturating new-flood count and the first time each origin was seen; an origin
// that finds the table full is flagged with gateway_full and not stored. Exactly one result
// comes back per request, in order. The pair RAM has one read port and is read once per
// cycle during a scan, so a new pair waits until every held pair is read, and a duplicate
// found in slot j until slots 0 to j are read; one request is in work at a time, and a
// finished result waits in the output register, which may hold the block's last write
// cycle while rsp_stall is high. No clearing pass follows reset.
module flood_duplicate_tracker (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  fdt_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fdt_pkg::rsp_type rsp_data
);
   import fdt_pkg::*;

   // command and status between the controller and the datapath
   cmd_type    cmd;
   status_type status;

   // sequence each request: accept, scan the pair store, then write back and load a result
   fdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the pair RAM, the gateway table and the result register
   fdt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the flood duplicate tracker: predicted results vs. the block.
`timescale 1ns / 100ps

module testbench;
   import fdt_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * PAIR_DEPTH + 16;
   localparam int HISTORY_DEPTH  = 200;
   localparam int VERDICT_DEPTH  = 4096;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int REPEAT_HITS    = 30;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   flood_duplicate_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Idle rates in percent, changed between phases of the run.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   int unsigned mismatches  = 0;
   int unsigned idle_cycles = 0;

   // Results still owed by the block: written at verdict_wr, checked at verdict_rd.
   rsp_type     verdict_log [VERDICT_DEPTH];
   int unsigned verdict_wr = 0;
   int unsigned verdict_rd = 0;
   // Recently sent floods, replayed later whether still held or already evicted.
   req_type     recent_floods [HISTORY_DEPTH];
   int unsigned recent_count = 0;
   int unsigned recent_next  = 0;

   // Origins that end up owning the gateway table; the table never frees a slot.
   logic [31:0] origin_pool [GATEWAY_DEPTH];
   logic [31:0] tick_now = '0;

   // Predicted state: ring of recent pairs and the gateway table.
   logic [31:0] held_addr [PAIR_DEPTH];
   logic [31:0] held_seq  [PAIR_DEPTH];
   logic [15:0] held_hits [PAIR_DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_used = 0;
   bit          origin_live   [GATEWAY_DEPTH];
   logic [31:0] origin_key    [GATEWAY_DEPTH];
   logic [31:0] origin_floods [GATEWAY_DEPTH];
   logic [31:0] origin_first  [GATEWAY_DEPTH];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int find_origin(logic [31:0] addr);
      int i;
      for (i = 0; i < GATEWAY_DEPTH; i++) begin
         if (origin_live[i] && origin_key[i] == addr) return i;
      end
      return -1;
   endfunction

   // Update the predicted state with one flood and return the result it must produce.
   function automatic rsp_type predict_flood(req_type item);
      rsp_type     verdict;
      int unsigned k, s;
      int          g, i;
      verdict = '0;
      // Scan from the oldest pair; the first match wins.
      for (k = 0; k < ring_used; k++) begin
         s = (ring_head + k) % PAIR_DEPTH;
         if (held_addr[s] == item.origin_addr && held_seq[s] == item.flood_seq) begin
            if (held_hits[s] != HITS_MAX) held_hits[s]++;
            g = find_origin(item.origin_addr);
            verdict.is_duplicate  = 1'b1;
            verdict.pair_count    = held_hits[s];
            verdict.gateway_first = (g >= 0) ? origin_first[g] : '0;
            return verdict;
         end
      end
      // New pair: append while room is left, else overwrite the oldest.
      if (ring_used < PAIR_DEPTH) begin
         s = (ring_head + ring_used) % PAIR_DEPTH;
         ring_used++;
      end else begin
         s = ring_head;
         ring_head = (ring_head + 1) % PAIR_DEPTH;
      end
      held_addr[s] = item.origin_addr;
      held_seq[s]  = item.flood_seq;
      held_hits[s] = 16'd1;
      verdict.pair_count = 16'd1;
      g = find_origin(item.origin_addr);
      if (g < 0) begin
         // Take the lowest free slot; drop the origin when none is left.
         for (i = 0; i < GATEWAY_DEPTH && g < 0; i++) begin
            if (!origin_live[i]) g = i;
         end
         if (g < 0) begin
            verdict.gateway_full = 1'b1;
            return verdict;
         end
         origin_live[g]   = 1'b1;
         origin_key[g]    = item.origin_addr;
         origin_floods[g] = '0;
         origin_first[g]  = item.now_ticks;
      end
      if (origin_floods[g] != COUNT_MAX) origin_floods[g]++;
      verdict.gateway_seen  = origin_floods[g];
      verdict.gateway_first = origin_first[g];
      return verdict;
   endfunction

   function automatic bit in_pool(logic [31:0] addr, int unsigned upto);
      int unsigned i;
      for (i = 0; i < upto; i++) begin
         if (origin_pool[i] == addr) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Present one request, hold it until accepted, then record what it must return.
   // Valid drops only across an idle gap, never within the step that raises it again.
   task automatic send_flood(input logic [31:0] addr, input logic [31:0] seq,
                             input logic [31:0] now_t);
      req_type item;
      item.origin_addr = addr;
      item.flood_seq   = seq;
      item.now_ticks   = now_t;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      verdict_log[verdict_wr % VERDICT_DEPTH] = predict_flood(item);
      verdict_wr++;
      recent_floods[recent_next] = item;
      recent_next = (recent_next + 1) % HISTORY_DEPTH;
      if (recent_count < HISTORY_DEPTH) recent_count++;
   endtask

   // Drive one pair into slot 0 and hit it repeatedly; its count climbs by one each time.
   task automatic test_repeat_hits();
      send_flood(origin_pool[0], '0, '0);
      repeat (REPEAT_HITS) send_flood(origin_pool[0], '0, $urandom);
   endtask

   // Walk the field extremes, fill the gateway table, then overflow it.
   task automatic test_field_extremes();
      int unsigned i;
      logic [31:0] stranger;
      send_flood('1, '1, '1);
      send_flood('1, '1, '0);
      send_flood(origin_pool[0], '1, tick_now);
      send_flood(origin_pool[2], '0, 32'h5555_5555);
      send_flood(origin_pool[3], 32'h5555_5555, 32'hAAAA_AAAA);
      for (i = 4; i < GATEWAY_DEPTH; i++) begin
         tick_now += $urandom_range(1, 100);
         send_flood(origin_pool[i], i, tick_now);
      end
      // The table is full now: a new origin is flagged, and its repeat reports no first time.
      do stranger = $urandom; while (in_pool(stranger, GATEWAY_DEPTH));
      send_flood(stranger, 32'd7, tick_now);
      send_flood(stranger, 32'd7, tick_now + 1);
      send_flood(origin_pool[1], 32'd1, tick_now + 2);
   endtask

   // Push the store past full, replay an evicted pair, then hit both ends of the ring.
   task automatic test_store_eviction();
      int unsigned n, k;
      for (n = 0; n < PAIR_DEPTH + 5; n++) begin
         tick_now += $urandom_range(1, 50);
         send_flood(origin_pool[n % GATEWAY_DEPTH], 32'hE000_0000 + n, tick_now);
      end
      send_flood(origin_pool[0], 32'hE000_0000, tick_now);
      send_flood(held_addr[ring_head], held_seq[ring_head], tick_now);
      k = (ring_head + ring_used - 1) % PAIR_DEPTH;
      send_flood(held_addr[k], held_seq[k], tick_now);
   endtask

   // Mostly realistic flood traffic: repeats of held pairs, replays of older floods,
   // fresh floods from known origins; the rest strangers and noise.
   task automatic test_random_floods(input int unsigned count);
      int unsigned n, pick, k;
      req_type     past;
      for (n = 0; n < count; n++) begin
         tick_now += $urandom_range(1, 5000);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            k = (ring_head + $urandom_range(0, ring_used - 1)) % PAIR_DEPTH;
            send_flood(held_addr[k], held_seq[k], tick_now);
         end else if (pick < 55) begin
            past = recent_floods[$urandom_range(0, recent_count - 1)];
            send_flood(past.origin_addr, past.flood_seq, tick_now);
         end else if (pick < 85) begin
            send_flood(origin_pool[$urandom_range(0, GATEWAY_DEPTH - 1)], $urandom, tick_now);
         end else if (pick < 95) begin
            send_flood($urandom, $urandom, tick_now);
         end else begin
            send_flood(origin_pool[$urandom_range(0, GATEWAY_DEPTH - 1)],
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom);
         end
      end
   endtask

   // Receiver side: stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   // Compare every accepted result against the oldest outstanding prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (verdict_rd == verdict_wr) begin
            mismatches++;
            $display("%0t: result expected none actual %h", $time, rsp_data);
         end else begin
            want = verdict_log[verdict_rd % VERDICT_DEPTH];
            verdict_rd++;
            check_field("is_duplicate", 32'(want.is_duplicate), 32'(rsp_data.is_duplicate));
            check_field("pair_count", 32'(want.pair_count), 32'(rsp_data.pair_count));
            check_field("gateway_seen", want.gateway_seen, rsp_data.gateway_seen);
            check_field("gateway_first", want.gateway_first, rsp_data.gateway_first);
            check_field("gateway_full", 32'(want.gateway_full), 32'(rsp_data.gateway_full));
         end
      end
   end

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("flood_duplicate_tracker: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned i, phase;
      int unsigned phase_send  [4] = '{0, 75, 0, 25};
      int unsigned phase_stall [4] = '{0, 0, 75, 25};
      // Fixed corner origins first, then distinct random ones.
      origin_pool[0] = '0;
      origin_pool[1] = '1;
      origin_pool[2] = 32'hAAAA_AAAA;
      origin_pool[3] = 32'h5555_5555;
      for (i = 4; i < GATEWAY_DEPTH; i++) begin
         do origin_pool[i] = $urandom; while (in_pool(origin_pool[i], i));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_repeat_hits();
      test_field_extremes();
      send_idle_pct = 25;
      stall_pct     = 25;
      test_store_eviction();
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase_send[phase];
         stall_pct     = phase_stall[phase];
         test_random_floods(RANDOM_PER_PHASE);
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays.
      while (verdict_rd != verdict_wr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("flood_duplicate_tracker: match");
      end else begin
         $display("flood_duplicate_tracker: mismatch");
      end
      $finish;
   end

endmodule
